/* rtl/clcd_pkg.sv */
package clcd_pkg;

   // width of the content length value and the payload counter
   localparam int LEN_BITS = 32;

   typedef enum logic [2:0] {
      PH_MSG_START,
      PH_LINE_START,
      PH_LINE_KEY,
      PH_LINE_VALUE,
      PH_FIELD_LF,
      PH_HDR_LF,
      PH_PAYLOAD
   } clcd_phase_type;

   typedef enum logic [3:0] {
      ST_PROGRESS      = 4'd0,
      ST_OK            = 4'd1,
      ST_LOST          = 4'd2,
      ST_BARE_LF       = 4'd3,
      ST_BAD_FIELD_END = 4'd4,
      ST_BAD_HDR_END   = 4'd5,
      ST_BAD_LENGTH    = 4'd6,
      ST_BAD_TYPE      = 4'd7,
      ST_BAD_CHARSET   = 4'd8
   } clcd_status_type;

   typedef enum logic [1:0] {
      VD_OK,
      VD_BAD_TYPE,
      VD_BAD_CHARSET
   } clcd_verdict_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } clcd_item_type;

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            has_byte;
      logic            last;
      clcd_status_type status;
   } clcd_result_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0B, 8'h0C};
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
   endfunction

   // "content-length", lower case
   function automatic logic [7:0] len_key_char(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:  r = "c";
         4'd1:  r = "o";
         4'd2:  r = "n";
         4'd3:  r = "t";
         4'd4:  r = "e";
         4'd5:  r = "n";
         4'd6:  r = "t";
         4'd7:  r = "-";
         4'd8:  r = "l";
         4'd9:  r = "e";
         4'd10: r = "n";
         4'd11: r = "g";
         4'd12: r = "t";
         4'd13: r = "h";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "content-type", lower case
   function automatic logic [7:0] type_key_char(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:  r = "c";
         4'd1:  r = "o";
         4'd2:  r = "n";
         4'd3:  r = "t";
         4'd4:  r = "e";
         4'd5:  r = "n";
         4'd6:  r = "t";
         4'd7:  r = "-";
         4'd8:  r = "t";
         4'd9:  r = "y";
         4'd10: r = "p";
         4'd11: r = "e";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // required media type prefix, 26 characters, case sensitive
   function automatic logic [7:0] prefix_char(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0:  r = "a";
         5'd1:  r = "p";
         5'd2:  r = "p";
         5'd3:  r = "l";
         5'd4:  r = "i";
         5'd5:  r = "c";
         5'd6:  r = "a";
         5'd7:  r = "t";
         5'd8:  r = "i";
         5'd9:  r = "o";
         5'd10: r = "n";
         5'd11: r = "/";
         5'd12: r = "v";
         5'd13: r = "s";
         5'd14: r = "c";
         5'd15: r = "o";
         5'd16: r = "d";
         5'd17: r = "e";
         5'd18: r = "-";
         5'd19: r = "j";
         5'd20: r = "s";
         5'd21: r = "o";
         5'd22: r = "n";
         5'd23: r = "r";
         5'd24: r = "p";
         5'd25: r = "c";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "charset="
   function automatic logic [7:0] mark_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = "c";
         3'd1: r = "h";
         3'd2: r = "a";
         3'd3: r = "r";
         3'd4: r = "s";
         3'd5: r = "e";
         3'd6: r = "t";
         3'd7: r = "=";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

/* rtl/clcd_parser.sv */
module clcd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  clcd_pkg::clcd_item_type   item,
   output logic                     emit,
   output clcd_pkg::clcd_result_type result
);
   import clcd_pkg::*;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [4:0] TP_DONE  = 5'd26;
   localparam logic [4:0] TP_FAIL  = 5'd31;
   localparam logic [3:0] CS_VALUE    = 4'd8;
   localparam logic [3:0] CS_U        = 4'd9;
   localparam logic [3:0] CS_UT       = 4'd10;
   localparam logic [3:0] CS_UTF      = 4'd11;
   localparam logic [3:0] CS_UTF_DASH = 4'd12;
   localparam logic [3:0] CS_COMPLETE = 4'd13;
   localparam logic [3:0] CS_BAD      = 4'd14;
   localparam logic [3:0] CS_CLOSED   = 4'd15;

   clcd_phase_type        phase_ff, phase_in;
   logic [4:0]            keyp_ff, keyp_in;     // [3:0] chars seen, [4] trailing ws
   logic [1:0]            cand_ff, cand_in;     // [0] length key, [1] type key
   logic [LEN_BITS-1:0]   acc_ff, acc_in;
   logic [2:0]            lflags_ff, lflags_in; // [0] digit, [1] ws after, [2] error
   logic [LEN_BITS-1:0]   clen_ff, clen_in;
   logic [LEN_BITS-1:0]   remain_ff, remain_in;
   logic [4:0]            tp_ff, tp_in;
   logic [3:0]            cp_ff, cp_in;
   clcd_verdict_type      verdict_ff, verdict_in;

   logic [7:0]            c;
   logic                  eos;
   logic                  restart;
   clcd_status_type       verdict_st;

   // key matcher, also fed with a freshly cleared line on the first key byte
   logic                  key_src_sel;
   logic [4:0]            kc_keyp_src, kc_keyp;
   logic [1:0]            kc_cand_src, kc_cand;
   logic                  kc_to_value;
   logic [3:0]            kc_n;
   logic [7:0]            kc_lower;

   // length and type value matchers
   logic [LEN_BITS+3:0]   acc_x10;
   logic [LEN_BITS-1:0]   lc_acc;
   logic [2:0]            lc_flags;
   logic [4:0]            tc_tp;
   logic [3:0]            tc_cp;

   assign c   = item.in_byte;
   assign eos = item.end_of_stream;

   always_comb begin
      case (verdict_ff)
         VD_OK:       verdict_st = ST_OK;
         VD_BAD_TYPE: verdict_st = ST_BAD_TYPE;
         default:     verdict_st = ST_BAD_CHARSET;
      endcase
   end

   always_comb begin
      key_src_sel = (phase_ff == PH_LINE_KEY);
      kc_keyp_src = key_src_sel ? keyp_ff : 5'd0;
      kc_cand_src = key_src_sel ? cand_ff : 2'b11;
      kc_n        = kc_keyp_src[3:0];
      kc_lower    = to_lower(c);
      kc_keyp     = kc_keyp_src;
      kc_cand     = kc_cand_src;
      kc_to_value = 1'b0;
      if (c == ":") begin
         kc_to_value = 1'b1;
         if (kc_cand_src[0] && kc_n == 4'd14) begin
            kc_cand = 2'b01;
         end else if (kc_cand_src[1] && kc_n == 4'd12) begin
            kc_cand = 2'b10;
         end else begin
            kc_cand = 2'b00;
         end
      end else if (is_ws(c)) begin
         if (kc_n != 4'd0) begin
            kc_keyp[4] = 1'b1;
         end
      end else if (kc_keyp_src[4]) begin
         kc_cand = 2'b00;
      end else begin
         if (kc_n >= 4'd14 || kc_lower != len_key_char(kc_n)) begin
            kc_cand[0] = 1'b0;
         end
         if (kc_n >= 4'd12 || kc_lower != type_key_char(kc_n)) begin
            kc_cand[1] = 1'b0;
         end
         if (kc_n != 4'd15) begin
            kc_keyp = {1'b0, kc_n + 4'd1};
         end
      end
   end

   // acc * 10 + digit; any carry above LEN_BITS is an overflow
   assign acc_x10 = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                  + {{(LEN_BITS){1'b0}}, c[3:0] - 4'd0};

   always_comb begin
      lc_acc   = acc_ff;
      lc_flags = lflags_ff;
      if (!lflags_ff[2]) begin
         if (is_ws(c)) begin
            if (lflags_ff[0]) begin
               lc_flags[1] = 1'b1;
            end
         end else if ((c inside {["0":"9"]}) && !lflags_ff[1]) begin
            if (acc_x10[LEN_BITS+3:LEN_BITS] != 4'd0) begin
               lc_flags[2] = 1'b1;
            end else begin
               lc_acc      = acc_x10[LEN_BITS-1:0];
               lc_flags[0] = 1'b1;
            end
         end else begin
            lc_flags[2] = 1'b1;
         end
      end
   end

   always_comb begin
      tc_tp = tp_ff;
      if (tp_ff < TP_DONE && !(tp_ff == 5'd0 && is_ws(c))) begin
         tc_tp = (c == prefix_char(tp_ff)) ? tp_ff + 5'd1 : TP_FAIL;
      end
      tc_cp = cp_ff;
      if (cp_ff < CS_VALUE) begin
         if (c == mark_char(cp_ff[2:0])) begin
            tc_cp = cp_ff + 4'd1;
         end else begin
            tc_cp = (c == "c") ? 4'd1 : 4'd0;
         end
      end else begin
         case (cp_ff)
            CS_VALUE:    tc_cp = is_ws(c) ? CS_VALUE : ((c == "u") ? CS_U : CS_BAD);
            CS_U:        tc_cp = (c == "t") ? CS_UT : CS_BAD;
            CS_UT:       tc_cp = (c == "f") ? CS_UTF : CS_BAD;
            CS_UTF:      tc_cp = (c == "-") ? CS_UTF_DASH
                                 : ((c == "8") ? CS_COMPLETE : CS_BAD);
            CS_UTF_DASH: tc_cp = (c == "8") ? CS_COMPLETE : CS_BAD;
            CS_COMPLETE: tc_cp = (c == ";") ? CS_CLOSED
                                 : (is_ws(c) ? CS_COMPLETE : CS_BAD);
            default:     tc_cp = cp_ff;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      keyp_in    = keyp_ff;
      cand_in    = cand_ff;
      acc_in     = acc_ff;
      lflags_in  = lflags_ff;
      clen_in    = clen_ff;
      remain_in  = remain_ff;
      tp_in      = tp_ff;
      cp_in      = cp_ff;
      verdict_in = verdict_ff;
      restart    = 1'b0;
      emit       = 1'b0;
      result     = '{data_byte: 8'h00, has_byte: 1'b0, last: 1'b1, status: ST_PROGRESS};
      case (phase_ff)
         PH_PAYLOAD: begin
            emit = 1'b1;
            if (eos) begin
               restart       = 1'b1;
               result.status = ST_LOST;
            end else if ((remain_ff >> 1) == '0) begin
               restart          = 1'b1;
               result.data_byte = c;
               result.has_byte  = 1'b1;
               result.status    = verdict_st;
            end else begin
               remain_in        = remain_ff - {{(LEN_BITS-1){1'b0}}, 1'b1};
               result.data_byte = c;
               result.has_byte  = 1'b1;
               result.last      = 1'b0;
            end
         end
         PH_HDR_LF: begin
            if (eos || c != CH_LF) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = ST_BAD_HDR_END;
            end else if (clen_ff == '0) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = verdict_st;
            end else begin
               remain_in = clen_ff;
               phase_in  = PH_PAYLOAD;
            end
         end
         PH_FIELD_LF: begin
            if (eos || c != CH_LF) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = ST_BAD_FIELD_END;
            end else begin
               phase_in = PH_LINE_START;
            end
         end
         PH_LINE_KEY, PH_LINE_VALUE: begin
            if (eos) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = ST_LOST;
            end else if (c == CH_LF) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = ST_BARE_LF;
            end else if (c == CH_CR) begin
               phase_in = PH_FIELD_LF;
               if (phase_ff == PH_LINE_VALUE) begin
                  if (cand_ff == 2'b01) begin
                     if (lflags_ff[2] || !lflags_ff[0]) begin
                        restart       = 1'b1;
                        emit          = 1'b1;
                        result.status = ST_BAD_LENGTH;
                     end else begin
                        clen_in = acc_ff;
                     end
                  end else if (cand_ff == 2'b10) begin
                     if (tp_ff != TP_DONE) begin
                        verdict_in = VD_BAD_TYPE;
                     end else if (cp_ff < CS_VALUE || cp_ff == CS_COMPLETE
                                  || cp_ff == CS_CLOSED) begin
                        verdict_in = VD_OK;
                     end else begin
                        verdict_in = VD_BAD_CHARSET;
                     end
                  end
               end
            end else if (phase_ff == PH_LINE_KEY) begin
               keyp_in = kc_keyp;
               cand_in = kc_cand;
               if (kc_to_value) begin
                  phase_in = PH_LINE_VALUE;
               end
            end else if (cand_ff == 2'b01) begin
               acc_in    = lc_acc;
               lflags_in = lc_flags;
            end else if (cand_ff == 2'b10) begin
               tp_in = tc_tp;
               cp_in = tc_cp;
            end
         end
         default: begin
            if (eos) begin
               restart = 1'b1;
               if (phase_ff == PH_LINE_START) begin
                  emit          = 1'b1;
                  result.status = ST_LOST;
               end
            end else if (c == CH_CR) begin
               phase_in = PH_HDR_LF;
            end else if (c == CH_LF) begin
               restart       = 1'b1;
               emit          = 1'b1;
               result.status = ST_BARE_LF;
            end else begin
               // new line: matcher starts from a cleared line
               acc_in    = '0;
               lflags_in = 3'd0;
               tp_in     = 5'd0;
               cp_in     = 4'd0;
               keyp_in   = kc_keyp;
               cand_in   = kc_cand;
               phase_in  = kc_to_value ? PH_LINE_VALUE : PH_LINE_KEY;
            end
         end
      endcase
      if (restart) begin
         phase_in   = PH_MSG_START;
         clen_in    = '0;
         remain_in  = '0;
         verdict_in = VD_OK;
         keyp_in    = 5'd0;
         cand_in    = 2'b11;
         acc_in     = '0;
         lflags_in  = 3'd0;
         tp_in      = 5'd0;
         cp_in      = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MSG_START;
         keyp_ff    <= 5'd0;
         cand_ff    <= 2'b11;
         acc_ff     <= '0;
         lflags_ff  <= 3'd0;
         clen_ff    <= '0;
         remain_ff  <= '0;
         tp_ff      <= 5'd0;
         cp_ff      <= 4'd0;
         verdict_ff <= VD_OK;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         keyp_ff    <= keyp_in;
         cand_ff    <= cand_in;
         acc_ff     <= acc_in;
         lflags_ff  <= lflags_in;
         clen_ff    <= clen_in;
         remain_ff  <= remain_in;
         tp_ff      <= tp_in;
         cp_ff      <= cp_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

/* rtl/content_length_deframer.sv */
// Content-length deframer: header-framed byte stream in, payload words out.
// Each word waits in the input register; its result, if any, is registered.
// Throughput: one word per cycle; the input register stalls only when the
// parser owes a result and the output register is full and not being taken.
// Reset (synchronous, active high) empties both registers and puts the
// parser at message start with a zero length and the default content type.
module content_length_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [4:0] rsp_tuser,   // [0] has_byte, [4:1] status
   output logic       rsp_tlast    // last
);
   import clcd_pkg::*;

   // input register: one word waiting for the parser
   logic            in_valid_ff, in_valid_in;
   clcd_item_type   in_item_ff;

   // output register: one result waiting for the sink
   logic            out_valid_ff, out_valid_in;
   clcd_result_type out_res_ff;

   logic            emit;
   clcd_result_type res;
   logic            out_free;
   logic            advance;

   // the parser step runs when its result, if any, has room
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || advance;

   clcd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .emit    (emit),
      .result  (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= '{in_byte: req_tdata, end_of_stream: req_tlast};
      end
      if (advance && emit) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.data_byte;
   assign rsp_tuser  = {out_res_ff.status, out_res_ff.has_byte};
   assign rsp_tlast  = out_res_ff.last;

   // a result that does not close a message always carries a payload byte
   a_nonlast_has_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff.last |-> out_res_ff.has_byte
         && out_res_ff.status == ST_PROGRESS)
      else $error("non-last result without payload byte");

   // an in-progress status never closes a message
   a_progress_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status == ST_PROGRESS |-> !out_res_ff.last)
      else $error("progress status on last result");

   // input side stalls only behind a full output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // a stalled result is not overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_res_ff))
      else $error("pending result changed");

endmodule
